// ===== rtl/frwd_pkg.sv =====
package frwd_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned WORD_BYTES_W = 64;
  localparam int unsigned WORD_LEN_W   = 4;
  localparam int unsigned OUT_TDATA_W  = 72;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
  localparam logic [CHAR_W-1:0] END_CODE   = 8'd0;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_NONE  = 1'b1;

  typedef struct packed {
    logic                    overflow;
    logic [WORD_LEN_W-1:0]   word_length;
    logic [WORD_BYTES_W-1:0] word_bytes;
  } frwd_result_t;

endpackage

// ===== rtl/first_repeated_word_detector_unit.sv =====
// First repeated word detector. Bytes arrive on the slave stream, one per
// transaction; a space separates words and a zero byte ends the string. A
// byte that closes a non-empty word scans the word table through the single
// read port of the table memory, one entry per cycle, over at most the n
// words stored so far in the string (at most MAX_WORDS); no byte is taken
// during the scan or while a new result waits for the output register.
// A repeated word is reported at once (tuser = 0) and the rest of the string
// is ignored; an end byte without a repetition reports tuser = 1 with zero
// word and length. Words are cut to MAX_WORD_LEN bytes and only MAX_WORDS
// words are kept; either case sets the overflow bit of the result. No
// clearing pass is needed after reset.
module first_repeated_word_detector_unit #(
  parameter int unsigned MAX_WORDS    = 64,
  parameter int unsigned MAX_WORD_LEN = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: char_code[7:0]
  input  logic [frwd_pkg::CHAR_W-1:0]         s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: word_bytes[63:0], word_length[67:64], overflow[68], zero[71:69]
  output logic [frwd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: status[0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);

  localparam int unsigned W  = MAX_WORD_LEN * 8;
  localparam int unsigned LW = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [W-1:0]  cur_word_q, cur_word_d;
  logic [LW-1:0] cur_len_q, cur_len_d;
  logic [CW-1:0] seen_cnt_q, seen_cnt_d;
  logic          skip_q, skip_d;
  logic          ovf_q, ovf_d;
  logic          has_word_q, has_word_d;
  logic          is_end_q, is_end_d;
  logic          match_q, match_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_vld_q, rd_vld_d;

  logic          out_vld_q, out_vld_d;
  logic          out_status_q, out_status_d;
  frwd_pkg::frwd_result_t out_res_q, out_res_d;

  logic          rd_en, wr_en;
  logic [W-1:0]  rd_data;
  logic          accept, hit, emit, out_free, ovf_now;
  logic [frwd_pkg::CHAR_W-1:0] ch;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata;
  assign hit           = rd_vld_q && (rd_data == cur_word_q);
  assign out_free      = !out_vld_q || m_axis_tready;
  assign emit          = match_q || is_end_q;
  assign ovf_now       = ovf_q || (has_word_q && !match_q && (seen_cnt_q == CW'(MAX_WORDS)));

  frwd_ram #(
    .WIDTH(W),
    .DEPTH(MAX_WORDS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(seen_cnt_q[AW-1:0]),
    .wdata_i(cur_word_q),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  always_comb begin
    state_d      = state_q;
    cur_word_d   = cur_word_q;
    cur_len_d    = cur_len_q;
    seen_cnt_d   = seen_cnt_q;
    skip_d       = skip_q;
    ovf_d        = ovf_q;
    has_word_d   = has_word_q;
    is_end_d     = is_end_q;
    match_d      = match_q;
    rd_idx_d     = rd_idx_q;
    rd_vld_d     = rd_vld_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_res_d    = out_res_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (skip_q) begin
            if (ch == frwd_pkg::END_CODE) begin
              cur_word_d = '0;
              cur_len_d  = '0;
              seen_cnt_d = '0;
              skip_d     = 1'b0;
              ovf_d      = 1'b0;
            end
          end else if (ch != frwd_pkg::SPACE_CODE && ch != frwd_pkg::END_CODE) begin
            if (cur_len_q < LW'(MAX_WORD_LEN)) begin
              for (int b = 0; b < MAX_WORD_LEN; b++) begin
                if (cur_len_q == LW'(b)) begin
                  cur_word_d[b*8 +: 8] = ch;
                end
              end
              cur_len_d = cur_len_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else if (cur_len_q != '0) begin
            has_word_d = 1'b1;
            is_end_d   = (ch == frwd_pkg::END_CODE);
            match_d    = 1'b0;
            rd_idx_d   = '0;
            rd_vld_d   = 1'b0;
            state_d    = ST_SCAN;
          end else if (ch == frwd_pkg::END_CODE) begin
            has_word_d = 1'b0;
            is_end_d   = 1'b1;
            match_d    = 1'b0;
            state_d    = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        // one table read issued per cycle, its data compared in the next cycle
        if (hit || (rd_idx_q == seen_cnt_q && !rd_vld_q)) begin
          match_d  = hit;
          rd_vld_d = 1'b0;
          state_d  = ST_DONE;
        end else if (rd_idx_q < seen_cnt_q) begin
          rd_en    = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          rd_vld_d = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
        end
      end

      ST_DONE: begin
        if (!emit || out_free) begin
          if (emit) begin
            out_vld_d = 1'b1;
            out_res_d.overflow = ovf_now;
            if (match_q) begin
              out_status_d          = frwd_pkg::STATUS_FOUND;
              out_res_d.word_bytes  = frwd_pkg::WORD_BYTES_W'(cur_word_q);
              out_res_d.word_length = frwd_pkg::WORD_LEN_W'(cur_len_q);
            end else begin
              out_status_d          = frwd_pkg::STATUS_NONE;
              out_res_d.word_bytes  = '0;
              out_res_d.word_length = '0;
            end
          end
          if (has_word_q && !match_q) begin
            if (seen_cnt_q < CW'(MAX_WORDS)) begin
              wr_en      = 1'b1;
              seen_cnt_d = seen_cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          cur_word_d = '0;
          cur_len_d  = '0;
          if (is_end_q) begin
            seen_cnt_d = '0;
            skip_d     = 1'b0;
            ovf_d      = 1'b0;
          end else if (match_q) begin
            skip_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_word_q <= '0;
      cur_len_q  <= '0;
      seen_cnt_q <= '0;
      skip_q     <= 1'b0;
      ovf_q      <= 1'b0;
      has_word_q <= 1'b0;
      is_end_q   <= 1'b0;
      match_q    <= 1'b0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_word_q <= cur_word_d;
      cur_len_q  <= cur_len_d;
      seen_cnt_q <= seen_cnt_d;
      skip_q     <= skip_d;
      ovf_q      <= ovf_d;
      has_word_q <= has_word_d;
      is_end_q   <= is_end_d;
      match_q    <= match_d;
      rd_idx_q   <= rd_idx_d;
      rd_vld_q   <= rd_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_res_q    <= out_res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = frwd_pkg::OUT_TDATA_W'(out_res_q);

endmodule

// ===== rtl/frwd_ram.sv =====
module frwd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/frwd_checker.sv =====
module frwd_checker #(
  parameter int unsigned MAX_WORD_LEN = 8
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [frwd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);

  logic [frwd_pkg::WORD_LEN_W-1:0] len;
  assign len = m_axis_tdata[frwd_pkg::WORD_BYTES_W +: frwd_pkg::WORD_LEN_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == frwd_pkg::STATUS_FOUND |->
      len != '0 && len <= frwd_pkg::WORD_LEN_W'(MAX_WORD_LEN))
    else $error("repeated word with bad length");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == frwd_pkg::STATUS_NONE |->
      len == '0 && m_axis_tdata[frwd_pkg::WORD_BYTES_W-1:0] == '0)
    else $error("no-repetition result carries a word");

  // the closing byte is followed by the scan or finish state, so a
  // result never rises right after an input transaction
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result raised right after an input transaction");

endmodule

bind first_repeated_word_detector_unit frwd_checker #(
  .MAX_WORD_LEN(MAX_WORD_LEN)
) u_frwd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

// ===== sim/tb_first_repeated_word_detector_unit.sv =====
module tb_first_repeated_word_detector_unit;

  localparam int unsigned MAX_WORDS    = 64;
  localparam int unsigned MAX_WORD_LEN = 8;
  localparam int unsigned TARGET_CHARS = 2025;
  localparam int unsigned TAIL_CYCLES  = 2 * MAX_WORDS + 40;
  localparam int unsigned LONG_HOLD    = 400;
  localparam logic [frwd_pkg::CHAR_W-1:0] CHAR_A = 8'h61;

  typedef struct packed {
    logic                   status;
    frwd_pkg::frwd_result_t body;
  } report_t;

  typedef struct {
    logic [frwd_pkg::CHAR_W-1:0] ch;
    bit                          drain;
    bit                          calm;
  } feed_item_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic [frwd_pkg::CHAR_W-1:0]      s_axis_tdata  = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [frwd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;

  first_repeated_word_detector_unit #(
    .MAX_WORDS   (MAX_WORDS),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // detector state mirrored on the testbench side
  logic [frwd_pkg::WORD_BYTES_W-1:0] cur_word   = '0;
  int unsigned                       cur_len    = 0;
  logic [frwd_pkg::WORD_BYTES_W-1:0] seen_words [MAX_WORDS];
  int unsigned                       seen_count = 0;
  bit                                skipping   = 1'b0;
  bit                                ovf_seen   = 1'b0;

  report_t     pending_reports[$];
  feed_item_t  char_feed[$];
  int unsigned chars_offered = 0;
  int unsigned chars_taken   = 0;
  int unsigned reports_taken = 0;
  int unsigned mismatches    = 0;
  int unsigned tx_gap        = 0;
  bit          calm_phase    = 1'b0;
  bit          long_hold     = 1'b0;
  bit          str_drain     = 1'b0;
  bit          str_calm      = 1'b0;

  function automatic void clear_string();
    cur_word   = '0;
    cur_len    = 0;
    seen_count = 0;
    skipping   = 1'b0;
    ovf_seen   = 1'b0;
  endfunction

  task automatic scan_char(input logic [frwd_pkg::CHAR_W-1:0] ch);
    report_t r;
    bit      hit;
    hit = 1'b0;
    if (skipping) begin
      if (ch == frwd_pkg::END_CODE) clear_string();
    end else if (ch != frwd_pkg::SPACE_CODE && ch != frwd_pkg::END_CODE) begin
      if (cur_len < MAX_WORD_LEN) begin
        cur_word[cur_len*8 +: 8] = ch;
        cur_len++;
      end else begin
        ovf_seen = 1'b1;
      end
    end else begin
      if (cur_len != 0) begin
        for (int j = 0; j < seen_count; j++) begin
          if (seen_words[j] == cur_word) hit = 1'b1;
        end
        if (hit) begin
          r.status           = frwd_pkg::STATUS_FOUND;
          r.body.word_bytes  = cur_word;
          r.body.word_length = cur_len[frwd_pkg::WORD_LEN_W-1:0];
          r.body.overflow    = ovf_seen;
          pending_reports.push_back(r);
          if (ch == frwd_pkg::END_CODE) begin
            clear_string();
          end else begin
            skipping = 1'b1;
            cur_word = '0;
            cur_len  = 0;
          end
        end else begin
          if (seen_count < MAX_WORDS) begin
            seen_words[seen_count] = cur_word;
            seen_count++;
          end else begin
            ovf_seen = 1'b1;
          end
          cur_word = '0;
          cur_len  = 0;
        end
      end
      if (!hit && ch == frwd_pkg::END_CODE) begin
        r.status           = frwd_pkg::STATUS_NONE;
        r.body.word_bytes  = '0;
        r.body.word_length = '0;
        r.body.overflow    = ovf_seen;
        pending_reports.push_back(r);
        clear_string();
      end
    end
  endtask

  task automatic log_mismatch(input string what, input report_t want, input report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: exp status %0b word %h len %0d ovf %0b, got status %0b word %h len %0d ovf %0b",
               what, want.status, want.body.word_bytes, want.body.word_length,
               want.body.overflow, got.status, got.body.word_bytes, got.body.word_length,
               got.body.overflow);
  endtask

  function automatic int unsigned idle_cycles(input bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [frwd_pkg::CHAR_W-1:0] word_char(input bit narrow);
    logic [frwd_pkg::CHAR_W-1:0] c;
    if (narrow) begin
      c = CHAR_A + frwd_pkg::CHAR_W'($urandom_range(0, 2));
    end else begin
      c = frwd_pkg::CHAR_W'($urandom_range(1, 255));
      if (c == frwd_pkg::SPACE_CODE) c = c + 1'b1;
    end
    return c;
  endfunction

  task automatic begin_string(input bit drain, input bit calm);
    str_drain = drain;
    str_calm  = calm;
  endtask

  task automatic add_char(input logic [frwd_pkg::CHAR_W-1:0] ch);
    feed_item_t it;
    it.ch     = ch;
    it.drain  = str_drain;
    it.calm   = str_calm;
    str_drain = 1'b0;
    char_feed.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // input transactions feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      scan_char(s_axis_tdata);
      chars_taken++;
    end
  end

  // driver
  always @(negedge clk_i) begin
    feed_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && chars_taken != chars_offered) begin
      // current transaction not taken yet
    end else if (tx_gap != 0) begin
      tx_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (char_feed.size() == 0 ||
                 (char_feed[0].drain && pending_reports.size() != 0)) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      item = char_feed.pop_front();
      s_axis_tdata  <= item.ch;
      s_axis_tvalid <= 1'b1;
      calm_phase    <= item.calm;
      chars_offered++;
      tx_gap = idle_cycles(item.calm);
    end
  end

  // receiver
  int unsigned rx_stall  = 0;
  int unsigned rx_drawn  = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_drawn != reports_taken) begin
        rx_drawn = reports_taken;
        rx_stall = idle_cycles(calm_phase);
      end
      m_axis_tready <= !long_hold && rx_stall == 0;
      if (rx_stall != 0) rx_stall--;
    end
  end

  // one long back-pressure stretch so the block stalls its input
  initial begin
    wait (chars_taken >= 700);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.body   = m_axis_tdata[$bits(frwd_pkg::frwd_result_t)-1:0];
      reports_taken++;
      if (pending_reports.size() == 0) begin
        want = '0;
        log_mismatch("unexpected result", want, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status ||
            got.body.word_bytes !== want.body.word_bytes ||
            got.body.word_length !== want.body.word_length ||
            got.body.overflow !== want.body.overflow)
          log_mismatch("mismatch", want, got);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned                 idx;
    int unsigned                 n;
    int unsigned                 len;
    int unsigned                 count;
    int unsigned                 pick;
    bit                          wide;
    logic [frwd_pkg::CHAR_W-1:0] base [MAX_WORD_LEN];

    // directed strings
    begin_string(1'b0, 1'b0);
    add_char(frwd_pkg::END_CODE);             // empty string
    add_text("a a b");                        // match, then rest skipped
    add_char(frwd_pkg::END_CODE);
    add_text("  q  q");                       // leading/double spaces, match on end byte
    add_char(frwd_pkg::END_CODE);
    add_char(8'hff); add_char(8'h01); add_char(frwd_pkg::SPACE_CODE);
    add_char(8'hff); add_char(8'h01); add_char(frwd_pkg::END_CODE);
    add_text("r s ");                         // trailing space, no repeat
    add_char(frwd_pkg::END_CODE);

    idx = 0;
    while (char_feed.size() < TARGET_CHARS) begin
      begin_string(idx % 25 == 10, $urandom_range(0, 3) == 0);
      pick = (idx < 2) ? idx : $urandom_range(2, 41);
      if (pick == 0 || pick == 41) begin
        // nearly fill, fill or overfill the word table with distinct two-letter words
        count = $urandom_range(MAX_WORDS - 4, MAX_WORDS + 6);
        for (int i = 0; i < count; i++) begin
          add_char(CHAR_A + frwd_pkg::CHAR_W'(i % 26));
          add_char(CHAR_A + frwd_pkg::CHAR_W'(i / 26));
          add_char(frwd_pkg::SPACE_CODE);
        end
        if ($urandom_range(0, 1) == 1) begin
          n = $urandom_range(0, count - 1);
          add_char(CHAR_A + frwd_pkg::CHAR_W'(n % 26));
          add_char(CHAR_A + frwd_pkg::CHAR_W'(n / 26));
        end
      end else if (pick < 6) begin
        // truncated words sharing their first bytes
        wide = $urandom_range(0, 1) == 1;
        for (int k = 0; k < MAX_WORD_LEN; k++) base[k] = word_char(!wide);
        for (int r = 0; r < 2; r++) begin
          if (r == 1 && $urandom_range(0, 3) == 0) base[MAX_WORD_LEN-1] = word_char(1'b0);
          for (int k = 0; k < MAX_WORD_LEN; k++) add_char(base[k]);
          len = $urandom_range(1, 3);
          repeat (len) add_char(word_char(1'b0));
          add_char(frwd_pkg::SPACE_CODE);
          if ($urandom_range(0, 1) == 1) begin
            add_char(word_char(1'b1));
            add_char(frwd_pkg::SPACE_CODE);
          end
        end
      end else if (pick < 14) begin
        len = $urandom_range(1, 20);
        repeat (len) add_char(frwd_pkg::CHAR_W'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) add_char(frwd_pkg::SPACE_CODE);
        n    = $urandom_range(1, 8);
        wide = $urandom_range(0, 3) == 0;
        for (int w = 0; w < n; w++) begin
          len = wide ? $urandom_range(1, 10) : $urandom_range(1, 3);
          repeat (len) add_char(word_char(!wide));
          if (w < n - 1 || $urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 2);
            repeat (len) add_char(frwd_pkg::SPACE_CODE);
          end
        end
      end
      add_char(frwd_pkg::END_CODE);
      idx++;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (char_feed.size() != 0 || chars_taken != chars_offered) @(negedge clk_i);
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
